FILE: src/manchester_frame_decoder_assert.svh
// Assertion macros shared by the decoder modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef MANCHESTER_FRAME_DECODER_ASSERT_SVH
`define MANCHESTER_FRAME_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MFD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("decoder check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define MFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("decoder check failed in the next cycle");

`endif

FILE: src/mfd_pkg.sv
package mfd_pkg;

    localparam int PAYLOAD_W = 6;

    // Bytes that the receive buffer can hold; positions at or past it are counted only.
    localparam logic [7:0] FIFO_BYTES    = 8'd96;
    localparam logic [7:0] HEADER_BYTES  = 8'd4;
    localparam logic [6:0] HEADER_LAST   = 7'd3;
    localparam logic [6:0] FIRST_DATA    = 7'd4;
    localparam logic [6:0] POS_MAX       = 7'd127;
    localparam logic [PAYLOAD_W-1:0] PAYLOAD_RESET = 6'd26;

    typedef struct packed {
        logic [7:0] manch_byte;
        logic       frame_last;
    } mfd_in_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] error_mask;
        logic       frame_end;
        logic       frame_ok;
    } mfd_out_t;

    typedef struct packed {
        logic     valid;
        mfd_out_t result;
    } mfd_push_t;

    typedef logic [PAYLOAD_W-1:0] mfd_cfg_t;

endpackage

FILE: src/mfd_stream_if.sv
interface mfd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

FILE: src/mfd_pair_decode.sv
module mfd_pair_decode (
    input  logic [7:0] manch_byte,
    output logic [3:0] data_nibble,
    output logic [3:0] error_nibble
);
    // Pair i sits at bits 2i+1:2i; the most significant pair gives bit 3.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            data_nibble[i]  = manch_byte[2*i];
            error_nibble[i] = ~(manch_byte[2*i+1] ^ manch_byte[2*i]);
        end
    end
endmodule

FILE: src/mfd_frame_ctrl.sv
module mfd_frame_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rx_fire,
    input  mfd_pkg::mfd_in_t  rx_item,
    input  logic              cfg_write,
    input  mfd_pkg::mfd_cfg_t cfg_data,
    output mfd_pkg::mfd_push_t push
);
    import mfd_pkg::*;

    mfd_cfg_t   payload_bytes_reg;
    logic [6:0] pos_reg, pos_next;
    logic [1:0] carry_data_reg, carry_data_next;
    logic [1:0] carry_err_reg, carry_err_next;
    logic [3:0] mid_data_reg, mid_data_next;
    logic [3:0] mid_err_reg, mid_err_next;

    logic [3:0] dn;
    logic [3:0] en;
    logic [7:0] exp_len;
    logic [7:0] pos_ext;
    logic       in_range;
    logic       emit;

    mfd_pair_decode u_decode (
        .manch_byte   (rx_item.manch_byte),
        .data_nibble  (dn),
        .error_nibble (en)
    );

    assign exp_len  = HEADER_BYTES + {1'b0, payload_bytes_reg, 1'b0};
    assign pos_ext  = {1'b0, pos_reg};
    assign in_range = (pos_ext < FIFO_BYTES) && (pos_ext < exp_len);
    // Data bytes complete on the second byte of each pair after the header.
    assign emit     = in_range && (pos_reg >= FIRST_DATA) && pos_reg[0];

    always_comb
    begin
        pos_next        = pos_reg;
        carry_data_next = carry_data_reg;
        carry_err_next  = carry_err_reg;
        mid_data_next   = mid_data_reg;
        mid_err_next    = mid_err_reg;
        if (rx_fire)
        begin
            if (in_range && (pos_reg == HEADER_LAST))
            begin
                carry_data_next = dn[1:0];
                carry_err_next  = en[1:0];
            end
            else if (in_range && (pos_reg >= FIRST_DATA) && !pos_reg[0])
            begin
                mid_data_next = dn;
                mid_err_next  = en;
            end
            else if (emit)
            begin
                carry_data_next = dn[1:0];
                carry_err_next  = en[1:0];
            end
            if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + 7'd1;
            end
            if (rx_item.frame_last)
            begin
                pos_next        = '0;
                carry_data_next = '0;
                carry_err_next  = '0;
                mid_data_next   = '0;
                mid_err_next    = '0;
            end
        end
    end

    always_comb
    begin
        push.valid             = rx_fire && (emit || rx_item.frame_last);
        push.result.data_byte  = emit ? {carry_data_reg, mid_data_reg, dn[3:2]} : 8'd0;
        push.result.error_mask = emit ? {carry_err_reg, mid_err_reg, en[3:2]} : 8'd0;
        push.result.frame_end  = rx_item.frame_last;
        push.result.frame_ok   = rx_item.frame_last && (exp_len <= FIFO_BYTES)
                                 && ((pos_ext + 8'd1) == exp_len);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            payload_bytes_reg <= PAYLOAD_RESET;
            pos_reg           <= '0;
            carry_data_reg    <= '0;
            carry_err_reg     <= '0;
            mid_data_reg      <= '0;
            mid_err_reg       <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                payload_bytes_reg <= cfg_data;
            end
            pos_reg        <= pos_next;
            carry_data_reg <= carry_data_next;
            carry_err_reg  <= carry_err_next;
            mid_data_reg   <= mid_data_next;
            mid_err_reg    <= mid_err_next;
        end
    end

`include "manchester_frame_decoder_assert.svh"

    `MFD_ASSERT_NEXT(a_last_clears_pos, rx_fire && rx_item.frame_last, pos_reg == 7'd0)
    `MFD_ASSERT_SAME(a_ok_needs_end, push.valid && push.result.frame_ok, push.result.frame_end)
    `MFD_ASSERT_SAME(a_data_on_odd_pos,
                     push.valid && !push.result.frame_end,
                     pos_reg[0] && (pos_reg > FIRST_DATA))

endmodule

FILE: src/mfd_out_stage.sv
module mfd_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  mfd_pkg::mfd_push_t push,
    output logic               in_ready,
    input  logic               out_ready,
    output logic               out_valid,
    output mfd_pkg::mfd_out_t  out_item
);
    import mfd_pkg::*;

    logic     valid_reg;
    mfd_out_t item_reg;
    logic     skid_valid_reg;
    mfd_out_t skid_item_reg;

    // A request that arrives while the output is stalled parks in the skid slot.
    assign in_ready  = !skid_valid_reg;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!valid_reg || out_ready)
            begin
                if (skid_valid_reg)
                begin
                    valid_reg      <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    valid_reg <= push.valid;
                end
            end
            else if (push.valid)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!valid_reg || out_ready)
        begin
            item_reg <= skid_valid_reg ? skid_item_reg : push.result;
        end
        else if (push.valid)
        begin
            skid_item_reg <= push.result;
        end
    end

`include "manchester_frame_decoder_assert.svh"

    `MFD_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, valid_reg)
    `MFD_ASSERT_NEXT(a_stall_fills_skid, push.valid && valid_reg && !out_ready, skid_valid_reg)
    `MFD_ASSERT_NEXT(a_skid_moves_up, skid_valid_reg && out_ready, valid_reg && !skid_valid_reg)

endmodule

FILE: src/manchester_frame_decoder.sv
// Manchester frame decoder.
// rx carries one received byte per request (four Manchester pairs, most
// significant pair first) and a flag that marks the last byte of a frame.
// result carries decoded data bytes with their per-bit error masks, and on the
// last byte of a frame the end flag and if its size matched and fit the FIFO.
// cfg writes the payload length in data bytes; it is always ready and should
// only be written while no frame is in flight.
// A result reaches result through the output register, or through the skid
// register first if the output is stalled. Throughput is one byte per cycle
// while rx is ready; a byte that gives no result is accepted all the same.
// When the receiver stalls, one result waits in the output register and one
// more in a skid register, so rx stays ready for one further request; rx ready
// drops only while the skid register is full.
// Reset clears the frame position, the carried bits and both output slots,
// and sets the payload length to 26 bytes.
module manchester_frame_decoder (
    input  logic         clk,
    input  logic         rst_n,
    mfd_stream_if.sink   rx,
    mfd_stream_if.source result,
    mfd_stream_if.sink   cfg
);
    import mfd_pkg::*;

    logic      rx_fire;
    logic      in_ready;
    mfd_push_t push;

    assign rx.ready  = in_ready;
    assign rx_fire   = rx.valid && in_ready;
    assign cfg.ready = 1'b1;

    mfd_frame_ctrl u_frame_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_fire   (rx_fire),
        .rx_item   (rx.payload),
        .cfg_write (cfg.valid),
        .cfg_data  (cfg.payload),
        .push      (push)
    );

    mfd_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_ready  (in_ready),
        .out_ready (result.ready),
        .out_valid (result.valid),
        .out_item  (result.payload)
    );

endmodule
